/* design/gss_pkg.sv */
`timescale 1ns / 1ps

package gss_pkg;

    // concentration word width (Q4.12 by default)
    localparam int CONC_W = 16;

    // config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int RATE_W     = 12;
    localparam int SIZE_W     = 10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KILL_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 3'd4;

    // reset values
    localparam logic [RATE_W-1:0] FEED_RESET = 12'd123;
    localparam logic [RATE_W-1:0] KILL_RESET = 12'd246;
    localparam logic [RATE_W-1:0] STEP_RESET = 12'd205;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd512;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 10'd3;

endpackage

/* design/gss_ram.sv */
`timescale 1ns / 1ps

module gss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/gray_scott_stencil_step.sv */
`timescale 1ns / 1ps

// Gray-Scott reaction-diffusion, one generation per frame, 5-point stencil.
// s_ channel: one word per grid cell, raster order (row outer), current A/B.
// m_ channel: results; cell (i-1,j) is produced when cell (i,j) arrives.
//   Inputs of row 0 produce nothing; inputs of the last row also produce the
//   zero border result for their own cell. m_tlast marks the last cell.
// Config: plain write port (cfg_we, cfg_index, cfg_wdata), write only while
//   idle. Grid size is clamped to [3, MAX_ROWS] x [3, MAX_COLS].
// Storage: both line buffers (two rows of A and B) share one simple dual-port
//   RAM of 2*MAX_COLS words with registered read.
// One word is taken at a time: s_tready is low until its results are queued.
//   Three RAM reads go through the single read port, then the update runs
//   through seven registered multiply/add steps and a state that queues the results.
// Results sit in a 4-deep output queue, so a stalled m_tready does not hold
//   s_tready until the queue lacks room for two results.
// Reset (aresetn, synchronous, low): counters to cell (0,0), registers to
//   defaults, output queue empty. RAM contents are not cleared.
module gray_scott_stencil_step #(
    parameter int MAX_ROWS  = 512,
    parameter int MAX_COLS  = 512,
    parameter int FRAC_BITS = 12,
    localparam int RW     = $clog2(MAX_ROWS),
    localparam int CW     = $clog2(MAX_COLS),
    localparam int OUT_FW = RW + CW + 2 * gss_pkg::CONC_W,
    localparam int OUT_TW = ((OUT_FW + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [2*gss_pkg::CONC_W-1:0]     s_tdata,   // conc_a, conc_b
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [OUT_TW-1:0]                m_tdata,   // cell_row, cell_col, next_a,
                                                        // next_b, zero pad
    output logic                             m_tlast,   // frame_end
    input  logic                             cfg_we,
    input  logic [gss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gss_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int DW   = gss_pkg::CONC_W;
    localparam int AW   = $clog2(2 * MAX_COLS);
    localparam int ERW  = (RW + 1 > gss_pkg::SIZE_W) ? RW + 1 : gss_pkg::SIZE_W;
    localparam int ECW  = (CW + 1 > gss_pkg::SIZE_W) ? CW + 1 : gss_pkg::SIZE_W;
    localparam int LAPW = DW + 4;
    localparam int ABW  = 2 * DW;
    localparam int ABBW = ABW + DW;
    localparam int OMW  = ((FRAC_BITS > DW - 1) ? FRAC_BITS : DW - 1) + 2;
    localparam int PFW  = OMW + gss_pkg::RATE_W + 1;
    localparam int PKW  = DW + gss_pkg::RATE_W + 2;
    localparam int DAW  = ABBW;
    localparam int PAW  = DAW + gss_pkg::RATE_W + 1;

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD1  = 4'd1;
    localparam logic [3:0] S_RD2  = 4'd2;
    localparam logic [3:0] S_RD3  = 4'd3;
    localparam logic [3:0] S_M1   = 4'd4;
    localparam logic [3:0] S_M2   = 4'd5;
    localparam logic [3:0] S_M3   = 4'd6;
    localparam logic [3:0] S_M4   = 4'd7;
    localparam logic [3:0] S_M5   = 4'd8;
    localparam logic [3:0] S_M6   = 4'd9;
    localparam logic [3:0] S_M7   = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    typedef struct packed {
        logic                  last;
        logic signed [DW-1:0]  nb;
        logic signed [DW-1:0]  na;
        logic [CW-1:0]         col;
        logic [RW-1:0]         row;
    } res_t;

    // ---------------- configuration ----------------
    logic [gss_pkg::RATE_W-1:0] feed_reg, kill_reg, step_reg;
    logic [gss_pkg::SIZE_W-1:0] rows_cfg_reg, cols_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            feed_reg     <= gss_pkg::FEED_RESET;
            kill_reg     <= gss_pkg::KILL_RESET;
            step_reg     <= gss_pkg::STEP_RESET;
            rows_cfg_reg <= gss_pkg::SIZE_RESET;
            cols_cfg_reg <= gss_pkg::SIZE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                gss_pkg::CFG_FEED_RATE: feed_reg     <= cfg_wdata[gss_pkg::RATE_W-1:0];
                gss_pkg::CFG_KILL_RATE: kill_reg     <= cfg_wdata[gss_pkg::RATE_W-1:0];
                gss_pkg::CFG_TIME_STEP: step_reg     <= cfg_wdata[gss_pkg::RATE_W-1:0];
                gss_pkg::CFG_ROWS:      rows_cfg_reg <= cfg_wdata[gss_pkg::SIZE_W-1:0];
                gss_pkg::CFG_COLS:      cols_cfg_reg <= cfg_wdata[gss_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped grid size
    logic [ERW-1:0] rows_eff;
    logic [ECW-1:0] cols_eff;

    always_comb begin
        if (rows_cfg_reg < gss_pkg::SIZE_MIN) begin
            rows_eff = ERW'(gss_pkg::SIZE_MIN);
        end else if (ERW'(rows_cfg_reg) > ERW'(MAX_ROWS)) begin
            rows_eff = ERW'(MAX_ROWS);
        end else begin
            rows_eff = ERW'(rows_cfg_reg);
        end
        if (cols_cfg_reg < gss_pkg::SIZE_MIN) begin
            cols_eff = ECW'(gss_pkg::SIZE_MIN);
        end else if (ECW'(cols_cfg_reg) > ECW'(MAX_COLS)) begin
            cols_eff = ECW'(MAX_COLS);
        end else begin
            cols_eff = ECW'(cols_cfg_reg);
        end
    end

    // ---------------- control state ----------------
    logic [3:0]    state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;      // next incoming cell
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] i_reg;                  // cell being worked on
    logic [CW-1:0] j_reg;

    logic signed [DW-1:0] ina_reg, inb_reg;
    logic signed [DW-1:0] up_a_reg, up_b_reg, ca_reg, cb_reg;
    logic signed [DW-1:0] prev_a_reg, prev_b_reg;

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // wrap of the stored position against the current size
    logic [ERW-1:0] i_pre;
    logic [RW-1:0]  i_acc;
    logic [CW-1:0]  j_acc;

    always_comb begin
        if (ECW'(col_reg) >= cols_eff) begin
            j_acc = '0;
            i_pre = ERW'(row_reg) + ERW'(1);
        end else begin
            j_acc = col_reg;
            i_pre = ERW'(row_reg);
        end
        if (i_pre >= rows_eff) begin
            i_acc = '0;
        end else begin
            i_acc = i_pre[RW-1:0];
        end
    end

    // cell status
    logic has_res, last_row, last_col, interior, right_ok;
    assign right_ok = (ECW'(j_reg) + ECW'(1)) < cols_eff;
    assign has_res  = (i_reg != '0);
    assign last_row = (ERW'(i_reg) == rows_eff - ERW'(1));
    assign last_col = (ECW'(j_reg) == cols_eff - ECW'(1));
    assign interior = (ERW'(i_reg) >= ERW'(2)) && (j_reg != '0) && right_ok;

    // ---------------- line store ----------------
    // row parity picks the half: cur half holds row i-2, other half row i-1
    logic [AW-1:0]       cur_base, prv_base, raddr, waddr;
    logic                ram_we;
    logic [2*DW-1:0]     ram_rdata;
    logic signed [DW-1:0] rd_a, rd_b;

    always_comb begin
        cur_base = i_reg[0] ? AW'(MAX_COLS) : '0;
        prv_base = i_reg[0] ? '0 : AW'(MAX_COLS);
        case (state_reg)
            S_IDLE:  raddr = (i_acc[0] ? AW'(MAX_COLS) : AW'(0)) + AW'(j_acc);
            S_RD1:   raddr = prv_base + AW'(j_reg);
            default: raddr = prv_base + AW'(j_reg) + (right_ok ? AW'(1) : AW'(0));
        endcase
    end

    assign waddr  = cur_base + AW'(j_reg);
    assign ram_we = (state_reg == S_RD2);   // up tap already read at this address
    assign rd_a   = ram_rdata[DW-1:0];
    assign rd_b   = ram_rdata[2*DW-1:DW];

    gss_ram #(
        .WIDTH(2 * DW),
        .DEPTH(2 * MAX_COLS)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata ({inb_reg, ina_reg}),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // ---------------- update datapath ----------------
    logic signed [LAPW-1:0] lap_a_reg, lap_b_reg;
    logic signed [ABW-1:0]  p_ab_reg;
    logic signed [ABBW-1:0] p_abb_reg;
    logic signed [PFW-1:0]  p_f_reg;
    logic signed [PKW-1:0]  p_k_reg;
    logic signed [DAW-1:0]  da_reg, db_reg;
    logic signed [PAW-1:0]  pa_reg, pb_reg;

    logic signed [ABW-1:0]  ab_sh;
    logic signed [ABBW-1:0] react;
    logic signed [OMW-1:0]  one_m_ca;
    logic signed [PAW-1:0]  na_wide, nb_wide;
    logic signed [DW-1:0]   na_sat, nb_sat;

    assign ab_sh    = p_ab_reg >>> FRAC_BITS;
    assign react    = p_abb_reg >>> FRAC_BITS;
    assign one_m_ca = (OMW'(1) <<< FRAC_BITS) - OMW'(ca_reg);
    assign na_wide  = PAW'(ca_reg) + (pa_reg >>> FRAC_BITS);
    assign nb_wide  = PAW'(cb_reg) + (pb_reg >>> FRAC_BITS);

    always_comb begin
        if (na_wide > PAW'(32767)) begin
            na_sat = DW'(32767);
        end else if (na_wide < -PAW'(32768)) begin
            na_sat = DW'(-32768);
        end else begin
            na_sat = na_wide[DW-1:0];
        end
        if (nb_wide > PAW'(32767)) begin
            nb_sat = DW'(32767);
        end else if (nb_wide < -PAW'(32768)) begin
            nb_sat = DW'(-32768);
        end else begin
            nb_sat = nb_wide[DW-1:0];
        end
    end

    // read data lands in the state after its address: up in RD1, centre in RD2,
    // right tap from RD2 on (re-read in RD3, used in M1)
    always_ff @(posedge aclk) begin
        if (accept) begin
            ina_reg <= s_tdata[DW-1:0];
            inb_reg <= s_tdata[2*DW-1:DW];
            i_reg   <= i_acc;
            j_reg   <= j_acc;
        end
        case (state_reg)
            S_RD1: begin
                up_a_reg <= rd_a;
                up_b_reg <= rd_b;
            end
            S_RD2: begin
                ca_reg <= rd_a;
                cb_reg <= rd_b;
            end
            S_M1: begin
                p_ab_reg  <= ABW'(ca_reg) * ABW'(cb_reg);
                lap_a_reg <= LAPW'(up_a_reg) + LAPW'(ina_reg) + LAPW'(prev_a_reg)
                             + LAPW'(rd_a) - (LAPW'(ca_reg) <<< 2);
                lap_b_reg <= LAPW'(up_b_reg) + LAPW'(inb_reg) + LAPW'(prev_b_reg)
                             + LAPW'(rd_b) - (LAPW'(cb_reg) <<< 2);
            end
            S_M2: p_abb_reg <= ABBW'(ab_sh) * ABBW'(cb_reg);
            S_M3: p_f_reg   <= PFW'(signed'({1'b0, feed_reg})) * PFW'(one_m_ca);
            S_M4: p_k_reg   <= PKW'(signed'({2'b00, feed_reg} + {2'b00, kill_reg}))
                               * PKW'(cb_reg);
            S_M5: begin
                da_reg <= DAW'(lap_a_reg) - react + DAW'(p_f_reg >>> FRAC_BITS);
                db_reg <= DAW'(lap_b_reg) + react - DAW'(p_k_reg >>> FRAC_BITS);
            end
            S_M6: pa_reg <= PAW'(da_reg) * PAW'(signed'({1'b0, step_reg}));
            S_M7: pb_reg <= PAW'(db_reg) * PAW'(signed'({1'b0, step_reg}));
            default: ;
        endcase
    end

    // ---------------- output queue ----------------
    localparam int QD = 4;
    res_t         q_mem [QD];
    logic [1:0]   q_wp_reg, q_rp_reg;
    logic [2:0]   q_cnt_reg;
    logic         q_pop, q_push;
    logic [1:0]   q_nput;
    res_t         res0, res1;

    assign q_push = (state_reg == S_OUT) && (q_cnt_reg <= 3'(QD - 2));
    assign q_nput = q_push ? (2'(has_res) + 2'(last_row)) : 2'd0;
    assign q_pop  = m_tvalid && m_tready;

    always_comb begin
        res0.row  = i_reg - RW'(1);
        res0.col  = j_reg;
        res0.na   = interior ? na_sat : '0;
        res0.nb   = interior ? nb_sat : '0;
        res0.last = 1'b0;
        res1.row  = i_reg;
        res1.col  = j_reg;
        res1.na   = '0;
        res1.nb   = '0;
        res1.last = last_col;
    end

    always_ff @(posedge aclk) begin
        if (q_push && has_res) begin
            q_mem[q_wp_reg] <= res0;
            if (last_row) begin
                q_mem[q_wp_reg + 2'd1] <= res1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wp_reg  <= '0;
            q_rp_reg  <= '0;
            q_cnt_reg <= '0;
        end else begin
            q_wp_reg  <= q_wp_reg + q_nput;
            q_rp_reg  <= q_rp_reg + 2'(q_pop);
            q_cnt_reg <= q_cnt_reg + 3'(q_nput) - 3'(q_pop);
        end
    end

    assign m_tvalid = (q_cnt_reg != '0);
    assign m_tdata  = OUT_TW'({q_mem[q_rp_reg].nb, q_mem[q_rp_reg].na,
                               q_mem[q_rp_reg].col, q_mem[q_rp_reg].row});
    assign m_tlast  = q_mem[q_rp_reg].last;

    // ---------------- sequencer and position ----------------
    logic [ECW-1:0] col_inc;
    logic [ERW-1:0] row_inc;
    assign col_inc = ECW'(j_reg) + ECW'(1);
    assign row_inc = ERW'(i_reg) + ERW'(1);

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_RD1;
            S_RD1:  state_next = S_RD2;
            S_RD2:  state_next = S_RD3;
            S_RD3:  state_next = S_M1;
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_M4;
            S_M4:   state_next = S_M5;
            S_M5:   state_next = S_M6;
            S_M6:   state_next = S_M7;
            S_M7:   state_next = S_OUT;
            S_OUT: begin
                if (q_push) begin
                    state_next = S_IDLE;
                    if (col_inc >= cols_eff) begin
                        col_next = '0;
                        row_next = (row_inc >= rows_eff) ? '0 : row_inc[RW-1:0];
                    end else begin
                        col_next = col_inc[CW-1:0];
                        row_next = i_reg;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            row_reg    <= '0;
            col_reg    <= '0;
            prev_a_reg <= '0;
            prev_b_reg <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            // centre of this cell is the left tap of the next one
            if (state_reg == S_M1 && has_res) begin
                prev_a_reg <= ca_reg;
                prev_b_reg <= cb_reg;
            end
        end
    end

endmodule

/* bench/gray_scott_stencil_step_tb.sv */
`timescale 1ns / 1ps

// Gray-Scott stencil bench: raster frames of cells go in, per-cell updates come out.
// A local model of the line buffers and the fixed-point update predicts every
// result. A checker pops the oldest prediction on each m_ handshake.
module gray_scott_stencil_step_tb;

    localparam int MAX_COLS  = 512;
    localparam int FRAC_BITS = 12;
    localparam int OUT_TW    = 56;
    // index outside the register map; the block must ignore it
    localparam logic [gss_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
    // settle time before a config write
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [8:0]  row;
        logic [8:0]  col;
        logic [15:0] next_a;
        logic [15:0] next_b;
        logic        frame_end;
    } cell_update_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [2*gss_pkg::CONC_W-1:0]   s_tdata = '0;    // conc_a, conc_b
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [OUT_TW-1:0]              m_tdata;         // cell_row, cell_col, next_a, next_b, pad
    logic                           m_tlast;         // frame_end
    logic                           cfg_we = 1'b0;
    logic [gss_pkg::CFG_IDX_W-1:0]  cfg_index = gss_pkg::CFG_FEED_RATE;
    logic [gss_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    gray_scott_stencil_step u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // ---------------- model state ----------------
    logic [11:0] feed_q, kill_q, step_q;
    logic [9:0]  rows_q, cols_q;
    logic signed [15:0] a_lines [0:2*MAX_COLS-1];
    logic signed [15:0] b_lines [0:2*MAX_COLS-1];
    int unsigned row_pos, col_pos;
    longint left_a, left_b;

    cell_update_t pending_updates[$];
    int fail_count   = 0;
    int cells_sent   = 0;
    int updates_seen = 0;
    int frames_done  = 0;
    int hold_cycles  = 0;   // receiver hold-off requested by a test
    bit no_gaps      = 0;   // burst mode: neither side idles

    function automatic longint shr_frac(longint x);
        return x >>> FRAC_BITS;
    endfunction

    function automatic logic [15:0] sat16(longint x);
        if (x > 32767) return 16'h7fff;
        if (x < -32768) return 16'h8000;
        return x[15:0];
    endfunction

    function automatic int unsigned grid_dim(logic [9:0] v);
        if (v < 3) return 3;
        if (v > 512) return 512;
        return 32'(v);
    endfunction

    // Update the line-buffer model with one accepted cell and queue what it yields.
    task automatic predict_cell(logic signed [15:0] in_a, logic signed [15:0] in_b);
        int unsigned rows, cols, i, j, cur, prv;
        longint ua, ub, ca, cb, ra, rb, lap_a, lap_b, react, da, db, f, k;
        cell_update_t upd;
        rows = grid_dim(rows_q);
        cols = grid_dim(cols_q);
        if (col_pos >= cols) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= rows) row_pos = 0;
        i = row_pos;
        j = col_pos;
        cur = (i & 1) * MAX_COLS;
        prv = ((i + 1) & 1) * MAX_COLS;
        if (i >= 1) begin
            ua = a_lines[cur + j];
            ub = b_lines[cur + j];
            ca = a_lines[prv + j];
            cb = b_lines[prv + j];
            upd = '0;
            upd.row = 9'(i - 1);
            upd.col = 9'(j);
            // only interior cells get the stencil update
            if (i >= 2 && j >= 1 && j + 1 < cols) begin
                ra = a_lines[prv + j + 1];
                rb = b_lines[prv + j + 1];
                f = feed_q;
                k = kill_q;
                lap_a = ua + in_a + left_a + ra - 4 * ca;
                lap_b = ub + in_b + left_b + rb - 4 * cb;
                react = shr_frac(shr_frac(ca * cb) * cb);
                da = lap_a - react + shr_frac(f * ((longint'(1) << FRAC_BITS) - ca));
                db = lap_b + react - shr_frac((f + k) * cb);
                upd.next_a = sat16(ca + shr_frac(da * longint'(step_q)));
                upd.next_b = sat16(cb + shr_frac(db * longint'(step_q)));
            end
            pending_updates.push_back(upd);
            // last row: its own border cell follows, zero
            if (i == rows - 1) begin
                upd = '0;
                upd.row = 9'(i);
                upd.col = 9'(j);
                upd.frame_end = (j == cols - 1);
                pending_updates.push_back(upd);
            end
            left_a = ca;
            left_b = cb;
        end
        a_lines[cur + j] = in_a;
        b_lines[cur + j] = in_b;
        col_pos = j + 1;
        if (col_pos >= cols) begin
            col_pos = 0;
            row_pos = i + 1;
            if (row_pos >= rows) row_pos = 0;
        end
    endtask

    // ---------------- result checker ----------------
    always @(posedge aclk) begin
        cell_update_t want;
        if (aresetn && m_tvalid && m_tready) begin
            updates_seen++;
            if (pending_updates.size() == 0) begin
                $error("unexpected result word row=%0d col=%0d", m_tdata[8:0], m_tdata[17:9]);
                fail_count++;
            end else begin
                want = pending_updates.pop_front();
                if (m_tdata[8:0] !== want.row) begin
                    $error("cell_row: expected %0d, got %0d", want.row, m_tdata[8:0]);
                    fail_count++;
                end
                if (m_tdata[17:9] !== want.col) begin
                    $error("cell_col: expected %0d, got %0d", want.col, m_tdata[17:9]);
                    fail_count++;
                end
                if (m_tdata[33:18] !== want.next_a) begin
                    $error("next_a: expected %0d, got %0d", $signed(want.next_a),
                           $signed(m_tdata[33:18]));
                    fail_count++;
                end
                if (m_tdata[49:34] !== want.next_b) begin
                    $error("next_b: expected %0d, got %0d", $signed(want.next_b),
                           $signed(m_tdata[49:34]));
                    fail_count++;
                end
                if (m_tlast !== want.frame_end) begin
                    $error("frame_end: expected %0b, got %0b", want.frame_end, m_tlast);
                    fail_count++;
                end
                if (want.frame_end) frames_done++;
            end
        end
    end

    // ---------------- receiver back-pressure ----------------
    always @(posedge aclk) begin
        int r;
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (no_gaps) begin
            m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 65) m_tready <= 1'b1;
            else if (r < 97) m_tready <= 1'b0;
            else m_tready <= ~m_tready;  // rare flip keeps a few long stalls
        end
    end

    function automatic int idle_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] pick_conc();
        case ($urandom_range(0, 4))
            0, 1: return 16'($urandom());                          // anything
            2: return 16'(4096 + $urandom_range(0, 800) - 400);    // near 1.0
            3: return 16'($urandom_range(0, 1500));                // small positive
            default: begin
                case ($urandom_range(0, 2))
                    0: return 16'h7fff;
                    1: return 16'h8000;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    // Offer one cell word; s_tvalid stays high on return so back-to-back words
    // never drop it. drain_pipeline() lowers it.
    task automatic send_cell(logic [15:0] a, logic [15:0] b);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        do @(posedge aclk); while (!s_tready);
        predict_cell(a, b);
        cells_sent++;
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Pulse reset with nothing in flight; line contents survive on both sides.
    task automatic reset_dut();
        aresetn <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        row_pos = 0;
        col_pos = 0;
        left_a  = 0;
        left_b  = 0;
        feed_q  = gss_pkg::FEED_RESET;
        kill_q  = gss_pkg::KILL_RESET;
        step_q  = gss_pkg::STEP_RESET;
        rows_q  = gss_pkg::SIZE_RESET;
        cols_q  = gss_pkg::SIZE_RESET;
    endtask

    // Writes all five registers back to back plus one unmapped index.
    task automatic write_regs(logic [11:0] f, logic [11:0] k, logic [11:0] dt,
                              logic [11:0] rows, logic [11:0] cols);
        logic [gss_pkg::CFG_IDX_W-1:0] idx [6];
        logic [11:0] val [6];
        idx = '{gss_pkg::CFG_FEED_RATE, gss_pkg::CFG_KILL_RATE, gss_pkg::CFG_TIME_STEP,
                gss_pkg::CFG_ROWS, gss_pkg::CFG_COLS, CFG_UNMAPPED};
        val = '{f, k, dt, rows, cols, 12'hfff};
        for (int n = 0; n < 6; n++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[n];
            cfg_wdata <= val[n];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        feed_q = f;
        kill_q = k;
        step_q = dt;
        rows_q = rows[9:0];
        cols_q = cols[9:0];
    endtask

    task automatic send_random_frame();
        int unsigned total;
        total = grid_dim(rows_q) * grid_dim(cols_q);
        repeat (total) send_cell(pick_conc(), pick_conc());
    endtask

    // smallest grid, default rates, corner values of both fields
    task automatic test_smallest_grid();
        logic [15:0] vals [9];
        vals = '{16'h7fff, 16'h8000, 16'h0000, 16'h1000, 16'hffff,
                 16'h7fff, 16'h8000, 16'h0001, 16'h5555};
        write_regs(gss_pkg::FEED_RESET, gss_pkg::KILL_RESET, gss_pkg::STEP_RESET,
                   12'd3, 12'd3);
        for (int n = 0; n < 9; n++) send_cell(vals[n], ~vals[8 - n]);
        drain_pipeline();
    endtask

    // maximum rates drive the update into both saturation limits
    task automatic test_saturation();
        logic [15:0] vals [4];
        vals = '{16'h7fff, 16'h8000, 16'h0000, 16'hc000};
        write_regs(12'hfff, 12'hfff, 12'hfff, 12'd4, 12'd5);
        for (int n = 0; n < 20; n++) send_cell(vals[n % 4], vals[(n / 3) % 4]);
        drain_pipeline();
        // zero rates: pure identity update
        write_regs(12'd0, 12'd0, 12'd0, 12'd3, 12'd4);
        send_random_frame();
        drain_pipeline();
    endtask

    // out-of-range sizes clamp: below minimum, then a tall grid cut short by reset
    task automatic test_size_clamp();
        write_regs(gss_pkg::FEED_RESET, gss_pkg::KILL_RESET, gss_pkg::STEP_RESET,
                   12'd0, 12'd1);
        send_random_frame();
        drain_pipeline();
        write_regs(12'd100, 12'd300, 12'd2000, 12'hfff, 12'd2);
        repeat (24) send_cell(pick_conc(), pick_conc());
        drain_pipeline();
        reset_dut();
    endtask

    // output held off long enough to fill the queue and stall the input
    task automatic test_output_hold();
        write_regs(12'd200, 12'd250, 12'd400, 12'd4, 12'd6);
        hold_cycles = 300;
        send_random_frame();
        drain_pipeline();
    endtask

    task automatic test_random_frames();
        int start;
        start = cells_sent;
        while (cells_sent - start < 320) begin
            write_regs(12'($urandom()), 12'($urandom()), 12'($urandom()),
                       12'($urandom_range(3, 12)), 12'($urandom_range(3, 14)));
            no_gaps = ($urandom_range(0, 3) == 0);
            send_random_frame();
            drain_pipeline();
            no_gaps = 0;
        end
    endtask

    initial begin
        foreach (a_lines[n]) begin
            a_lines[n] = '0;
            b_lines[n] = '0;
        end
        row_pos = 0;
        col_pos = 0;
        left_a  = 0;
        left_b  = 0;
        feed_q  = gss_pkg::FEED_RESET;
        kill_q  = gss_pkg::KILL_RESET;
        step_q  = gss_pkg::STEP_RESET;
        rows_q  = gss_pkg::SIZE_RESET;
        cols_q  = gss_pkg::SIZE_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_smallest_grid();
        test_saturation();
        test_size_clamp();
        test_output_hold();
        test_random_frames();

        if (pending_updates.size() != 0) begin
            $error("%0d expected results never arrived", pending_updates.size());
            fail_count++;
        end
        $display("covered %0d cell words, %0d results, %0d full frames", cells_sent,
                 updates_seen, frames_done);
        $display("grids 3x3 up to 14 wide, clamped sizes, rate extremes, reset mid-frame, "
                 , "output hold-off");
        if (fail_count == 0) begin
            $display("gray_scott_stencil_step_tb: PASS");
        end else begin
            $display("gray_scott_stencil_step_tb: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("gray_scott_stencil_step_tb: FAIL");
        $finish;
    end

endmodule

/* gray_scott_stencil_step.f */
design/gss_pkg.sv
design/gss_ram.sv
design/gray_scott_stencil_step.sv
bench/gray_scott_stencil_step_tb.sv
